// File: hdl/alu_ps_pkg.sv
// ----------------------------------------------------------------------------
// alu_ps_pkg
// Shared types and codes for the arithmetic unit with prime search.
// ----------------------------------------------------------------------------
package alu_ps_pkg;

  // Operation codes (ASCII)
  localparam logic [7:0] OP_ADD   = 8'h2B;  // '+'
  localparam logic [7:0] OP_SUB   = 8'h2D;  // '-'
  localparam logic [7:0] OP_MUL   = 8'h2A;  // '*'
  localparam logic [7:0] OP_DIV   = 8'h2F;  // '/'
  localparam logic [7:0] OP_PRIME = 8'h70;  // 'p'

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_DIV_OVF  = 2'd2;
  localparam logic [1:0] ST_PRIME_ERR = 2'd3;

  localparam logic [31:0] MAX_S32 = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN_S32 = 32'h8000_0000;

  typedef struct packed {
    logic [7:0]         operation;
    logic signed [31:0] operand_b;
    logic signed [15:0] operand_c;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] answer;
    logic [1:0]         status;
  } out_item_t;

  // Request to and response from the shared divider
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_PNEXT,
    S_PTEST,
    S_PCHK,
    S_PDIV,
    S_DONE
  } state_e;

endpackage

// File: hdl/alu_ps_div.sv
// ----------------------------------------------------------------------------
// alu_ps_div
// Unsigned 32 by 32 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module alu_ps_div
  import alu_ps_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;

  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem_q, quo_q[31]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (busy_q) begin
      // restore when the trial subtraction goes negative
      if (!diff[32]) begin
        rem_d = diff[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted[31:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 5'd0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// File: hdl/alu_with_prime_search_core.sv
// ----------------------------------------------------------------------------
// alu_with_prime_search_core
// Arithmetic unit (add, subtract, multiply, divide) with a prime search,
// run by a small sequencer around one shared iterative divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_ready_o carries one item: an ASCII
//   operation byte and two signed operands. Output channel out_valid_o /
//   out_ready_i returns exactly one item per input item: answer and status.
//   The block works on one item at a time; in_ready_o is high only while
//   the sequencer is idle.
//   Add, subtract, multiply and unknown codes are computed in the execute
//   state and written to the output register from the done state, after
//   which the next item can be taken; divide waits for the shared divider,
//   which produces one quotient bit per cycle. The prime search runs trial
//   divisions on odd divisors up to the square root of each candidate,
//   each on the same divider, so its duration depends on the data (an even
//   candidate is passed over without a division, and a prime near the top
//   of the signed range needs the most divisions).
//   Reset clears the sequencer, the divider control and the output valid;
//   no item is held over.
//   A stalled receiver keeps the finished item in the output register; the
//   block takes a new item meanwhile and parks its result until the output
//   register is free.
// ----------------------------------------------------------------------------
module alu_with_prime_search_core
  import alu_ps_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  state_e state_q, state_d;

  // latched item
  logic [7:0]  op_q, op_d;
  logic [31:0] b_q, b_d;
  logic [31:0] c_q, c_d;         // second operand, sign-extended

  // result under construction
  logic [31:0] res_q, res_d;
  logic [1:0]  stat_q, stat_d;

  // prime search state
  logic [31:0] num_q, num_d;     // current candidate
  logic [14:0] cnt_q, cnt_d;     // primes still to find
  logic [15:0] dv_q, dv_d;       // trial divisor
  logic [31:0] sq_q, sq_d;       // trial divisor squared

  // output register
  out_item_t   out_q, out_d;
  logic        out_valid_q, out_valid_d;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic        in_fire;
  logic        out_free;
  logic        b_neg, c_neg;
  logic [31:0] b_mag, c_mag;
  logic [31:0] add_res, sub_res, mul_res;
  logic        c_zero, div_ovf;
  logic        cand_is_two, cand_even, sq_above;
  logic        last_prime;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign b_neg   = b_q[31];
  assign c_neg   = c_q[31];
  assign b_mag   = b_neg ? (32'd0 - b_q) : b_q;
  assign c_mag   = c_neg ? (32'd0 - c_q) : c_q;
  assign add_res = b_q + c_q;
  assign sub_res = b_q - c_q;
  assign mul_res = b_q * c_q;
  assign c_zero  = (c_q == 32'd0);
  assign div_ovf = (b_q == MIN_S32) && (c_q == 32'hFFFF_FFFF);

  assign cand_is_two = (num_q == 32'd2);
  assign cand_even   = !num_q[0];
  assign sq_above    = (sq_q > num_q);
  assign last_prime  = (cnt_q == 15'd1);

  alu_ps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (op_q)
          OP_DIV: state_d = (c_zero || div_ovf) ? S_DONE : S_DIV;
          OP_PRIME: state_d = (c_neg || c_zero) ? S_DONE : S_PNEXT;
          default: state_d = S_DONE;
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) state_d = S_DONE;
      end
      S_PNEXT: begin
        state_d = (num_q == MAX_S32) ? S_DONE : S_PTEST;
      end
      S_PTEST: begin
        if (cand_is_two) begin
          state_d = last_prime ? S_DONE : S_PNEXT;
        end else if (cand_even) begin
          state_d = S_PNEXT;
        end else begin
          state_d = S_PCHK;
        end
      end
      S_PCHK: begin
        if (sq_above) begin
          state_d = last_prime ? S_DONE : S_PNEXT;
        end else begin
          state_d = S_PDIV;
        end
      end
      S_PDIV: begin
        if (div_rsp.done) begin
          state_d = (div_rsp.rem == 32'd0) ? S_PNEXT : S_PCHK;
        end
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    op_d        = op_q;
    b_d         = b_q;
    c_d         = c_q;
    res_d       = res_q;
    stat_d      = stat_q;
    num_d       = num_q;
    cnt_d       = cnt_q;
    dv_d        = dv_q;
    sq_d        = sq_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    div_req     = '0;

    // drop the output item once taken
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d = in_item_i.operation;
          b_d  = in_item_i.operand_b;
          c_d  = {{16{in_item_i.operand_c[15]}}, in_item_i.operand_c};
        end
      end
      S_EXEC: begin
        stat_d = ST_OK;
        unique case (op_q)
          OP_ADD: res_d = add_res;
          OP_SUB: res_d = sub_res;
          OP_MUL: res_d = mul_res;
          OP_DIV: begin
            res_d = 32'd0;
            if (c_zero) begin
              stat_d = ST_DIV_ZERO;
            end else if (div_ovf) begin
              res_d  = MIN_S32;
              stat_d = ST_DIV_OVF;
            end else begin
              div_req.start    = 1'b1;
              div_req.dividend = b_mag;
              div_req.divisor  = c_mag;
            end
          end
          OP_PRIME: begin
            res_d = b_q;
            if (c_neg) stat_d = ST_PRIME_ERR;
            // values below 2 are never prime: start the search from 1
            num_d = (b_neg || b_q == 32'd0) ? 32'd1 : b_q;
            cnt_d = c_q[14:0];
          end
          default: res_d = 32'd0;
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_d = (b_neg != c_neg) ? (32'd0 - div_rsp.quot) : div_rsp.quot;
        end
      end
      S_PNEXT: begin
        if (num_q == MAX_S32) begin
          stat_d = ST_PRIME_ERR;
          res_d  = b_q;
        end else begin
          num_d = num_q + 32'd1;
        end
      end
      S_PTEST: begin
        if (cand_is_two) begin
          cnt_d = cnt_q - 15'd1;
          if (last_prime) res_d = num_q;
        end else begin
          dv_d = 16'd3;
          sq_d = 32'd9;
        end
      end
      S_PCHK: begin
        if (sq_above) begin
          cnt_d = cnt_q - 15'd1;
          if (last_prime) res_d = num_q;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = num_q;
          div_req.divisor  = {16'd0, dv_q};
        end
      end
      S_PDIV: begin
        if (div_rsp.done && div_rsp.rem != 32'd0) begin
          // (d+2)^2 = d^2 + 4d + 4
          dv_d = dv_q + 16'd2;
          sq_d = sq_q + {14'd0, dv_q, 2'b00} + 32'd4;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_d.answer = res_q;
          out_d.status = stat_q;
          out_valid_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    b_q    <= b_d;
    c_q    <= c_d;
    res_q  <= res_d;
    stat_q <= stat_d;
    num_q  <= num_d;
    cnt_q  <= cnt_d;
    dv_q   <= dv_d;
    sq_q   <= sq_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: dv/alu_with_prime_search_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alu_with_prime_search_core_tb
// Self-checking bench for the arithmetic unit with prime search. Sends
// directed corner items for add, subtract, multiply, divide, prime search and
// unknown codes, then a random mix. Both channels idle at random. Each result
// is checked field by field against an in-bench predictor, in order.
// ----------------------------------------------------------------------------
module alu_with_prime_search_core_tb;
  import alu_ps_pkg::*;

  // The prime searches used here are kept to small candidates, and most items
  // are short apart from stalls. A correct run stays well under this limit,
  // so it leaves ample margin.
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned RANDOM_ITEMS = 700;

  // One expectation: the item that was sent and the result it must give
  typedef struct packed {
    in_item_t  src;
    out_item_t res;
  } pending_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  pending_t    answer_q[$];
  pending_t    head;
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  bit          quiet;       // when set, neither side idles

  alu_with_prime_search_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // --------------------------------------------------------------------------
  // Clock and cycle guard
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort if the block hangs or loses an item
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("alu_with_prime_search_core_tb: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Primality by trial division over odd divisors; below 2 is never prime
  function automatic bit is_prime_val(longint v);
    longint d;
    if (v < 2) return 1'b0;
    if (v % 2 == 0) return v == 2;
    for (d = 3; d * d <= v; d += 2) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Work out the one result that an item must produce
  function automatic out_item_t alu_predict(in_item_t it);
    out_item_t   r;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] mag_b;
    logic [31:0] mag_c;
    logic [31:0] quo;
    longint      num;
    int          cnt;
    int          found;
    bit          overflow;
    r.answer = '0;
    r.status = ST_OK;
    b = it.operand_b;
    c = {{16{it.operand_c[15]}}, it.operand_c};
    case (it.operation)
      OP_ADD: r.answer = b + c;
      OP_SUB: r.answer = b - c;
      OP_MUL: r.answer = b * c;        // low 32 bits are sign-agnostic
      OP_DIV: begin
        if (c == '0) begin
          r.status = ST_DIV_ZERO;
        end else if (b == MIN_S32 && c == 32'hFFFF_FFFF) begin
          r.answer = MIN_S32;
          r.status = ST_DIV_OVF;
        end else begin
          // Divide magnitudes, then restore the sign: truncates toward zero
          mag_b = b[31] ? -b : b;
          mag_c = c[31] ? -c : c;
          quo   = mag_b / mag_c;
          r.answer = (b[31] ^ c[31]) ? -quo : quo;
        end
      end
      OP_PRIME: begin
        r.answer = b;
        cnt = $signed(it.operand_c);
        if (cnt < 0) begin
          r.status = ST_PRIME_ERR;
        end else begin
          num = $signed(b);
          if (num < 1) num = 1;
          found    = 0;
          overflow = 1'b0;
          while (found < cnt && !overflow) begin
            if (num >= longint'(MAX_S32)) begin
              overflow = 1'b1;
            end else begin
              num++;
              if (is_prime_val(num)) found++;
            end
          end
          if (overflow) r.status = ST_PRIME_ERR;
          else if (cnt > 0) r.answer = num[31:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly back to back or short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet) return 0;
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t mk_op(logic [7:0] op, logic [31:0] b, logic [15:0] c);
    in_item_t it;
    it.operation = op;
    it.operand_b = b;
    it.operand_c = c;
    return it;
  endfunction

  // Operand with a bias towards the corners of the range
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return MAX_S32;
      1: return MIN_S32;
      2: return $urandom_range(0, 2) == 0 ? 32'h0 : 32'hFFFF_FFFF;
      3: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_half();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return $urandom_range(0, 1) == 0 ? 16'h0001 : 16'hFFFF;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Present one item from a falling edge, hold it until it is taken, then
  // record what it must produce
  task automatic send_op(input in_item_t it);
    int unsigned gap;
    pending_t    p;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i  = it;
    do @(posedge clk_i); while (!in_ready_o);
    p.src = it;
    p.res = alu_predict(it);
    answer_q.push_back(p);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall in bursts, with long runs of ready too
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    hold        = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        out_ready_i = 1'b1;
        hold        = 0;
      end else if (hold != 0) begin
        hold--;
      end else if (out_ready_i) begin
        hold = pick_gap();
        if (hold != 0) begin
          out_ready_i = 1'b0;
          hold--;
        end
      end else begin
        out_ready_i = 1'b1;
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                           : $urandom_range(0, 20);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare every accepted result with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (answer_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("[%0t] result with nothing expected: answer %0d status %0d",
                   $realtime, out_item_o.answer, out_item_o.status);
      end else begin
        head = answer_q.pop_front();
        if (out_item_o.answer !== head.res.answer ||
            out_item_o.status !== head.res.status) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("[%0t] op %02h b %0d c %0d: answer exp %0d act %0d, status exp %0d act %0d",
                     $realtime, head.src.operation, head.src.operand_b,
                     head.src.operand_c, head.res.answer, out_item_o.answer,
                     head.res.status, out_item_o.status);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Wrap-around at both ends, back to back with no idling
  task automatic test_arith_extremes();
    quiet = 1'b1;
    send_op(mk_op(OP_ADD, MAX_S32, 16'h0001));
    send_op(mk_op(OP_ADD, MIN_S32, 16'h8000));
    send_op(mk_op(OP_SUB, MIN_S32, 16'h0001));
    send_op(mk_op(OP_SUB, MAX_S32, 16'h8000));
    send_op(mk_op(OP_MUL, MIN_S32, 16'hFFFF));
    send_op(mk_op(OP_MUL, MAX_S32, 16'h7FFF));
    send_op(mk_op(OP_MUL, 32'hDEAD_BEEF, 16'h0000));
    quiet = 1'b0;
  endtask

  // Divide by zero, the one overflowing quotient and every sign pairing
  task automatic test_divide();
    send_op(mk_op(OP_DIV, 32'd12345, 16'h0000));
    send_op(mk_op(OP_DIV, MIN_S32, 16'hFFFF));
    send_op(mk_op(OP_DIV, MIN_S32, 16'h8000));
    send_op(mk_op(OP_DIV, 32'd7, 16'hFFFE));
    send_op(mk_op(OP_DIV, -32'sd7, 16'h0002));
    send_op(mk_op(OP_DIV, -32'sd7, 16'hFFFE));
    send_op(mk_op(OP_DIV, MAX_S32, 16'h7FFF));
    send_op(mk_op(OP_DIV, 32'd3, 16'h0005));
  endtask

  // Count zero and negative, negative and tiny bases, and a search that
  // would pass the top of the signed range
  task automatic test_prime_search();
    send_op(mk_op(OP_PRIME, 32'h1234_5678, 16'h0000));
    send_op(mk_op(OP_PRIME, 32'd10, 16'hFFFF));
    send_op(mk_op(OP_PRIME, MAX_S32, 16'h8000));
    send_op(mk_op(OP_PRIME, MIN_S32, 16'h0002));
    send_op(mk_op(OP_PRIME, 32'd0, 16'h0003));
    send_op(mk_op(OP_PRIME, 32'd2, 16'h0001));
    send_op(mk_op(OP_PRIME, 32'd13, 16'h0001));
    send_op(mk_op(OP_PRIME, MAX_S32, 16'h0001));
    send_op(mk_op(OP_PRIME, 32'd100000, 16'h0002));
  endtask

  // Codes outside the set give zero whatever the operands
  task automatic test_unknown_ops();
    send_op(mk_op(8'h00, MAX_S32, 16'h7FFF));
    send_op(mk_op(8'hFF, MIN_S32, 16'h8000));
    send_op(mk_op(8'h71, 32'd5, 16'h0003));
  endtask

  // Random mix; prime searches kept to small bases and counts so the run
  // stays short, with the costly cases reached by cheap corner values
  task automatic test_random_mix();
    int unsigned n;
    int unsigned pick;
    logic [7:0]  op;
    logic [31:0] b;
    logic [15:0] c;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n < 60);
      pick  = $urandom_range(0, 99);
      b = rand_word();
      c = rand_half();
      if (pick < 20) begin
        op = OP_ADD;
      end else if (pick < 35) begin
        op = OP_SUB;
      end else if (pick < 50) begin
        op = OP_MUL;
      end else if (pick < 75) begin
        op = OP_DIV;
        case ($urandom_range(0, 19))
          0, 1: c = 16'h0000;
          2: begin
            b = MIN_S32;
            c = 16'hFFFF;
          end
          default: ;
        endcase
      end else if (pick < 87) begin
        op = OP_PRIME;
        case ($urandom_range(0, 19))
          0, 1: c = 16'h8000 | 16'($urandom_range(0, 32767));   // negative count
          2: c = 16'h0000;
          3: begin
            b = MAX_S32;
            c = 16'($urandom_range(1, 4));
          end
          4, 5, 6: begin
            b = {1'b1, 31'($urandom)};                          // negative base
            c = 16'($urandom_range(1, 4));
          end
          default: begin
            b = $urandom_range(0, 500);
            c = 16'($urandom_range(1, 4));
          end
        endcase
      end else begin
        do op = 8'($urandom); while (op == OP_PRIME);
      end
      send_op(mk_op(op, b, c));
    end
    quiet = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    quiet        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_arith_extremes();
    test_divide();
    test_prime_search();
    test_unknown_ops();
    test_random_mix();

    // Drop valid, drain every expectation, then watch for stray results
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("alu_with_prime_search_core_tb: PASS");
    end else begin
      $display("alu_with_prime_search_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: alu_with_prime_search_core.f
hdl/alu_ps_pkg.sv
hdl/alu_ps_div.sv
hdl/alu_with_prime_search_core.sv
dv/alu_with_prime_search_core_tb.sv
